### rtl/fat_cluster_chain_engine_unit_assert.svh
// Assertion macros used by the checker file of the cluster chain engine.
`ifndef FAT_CLUSTER_CHAIN_ENGINE_UNIT_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define FCCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define FCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fcce_pkg.sv
// Package with the types and constants of the cluster chain engine.
package fcce_pkg;

  localparam int ENTRIES      = 256;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int DATA_W       = 16;
  localparam int CNT_W        = 9;
  localparam int FIRST_USABLE = 2;
  localparam logic [DATA_W-1:0] END_MARK = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ALLOC = 2'd2,
    OP_FREE  = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_RD_DONE,
    DP_SCAN_STEP,
    DP_SCAN_HIT,
    DP_SCAN_FULL,
    DP_LINK,
    DP_MARK,
    DP_WALK
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic rd_zero;
    logic scan_last;
    logic walk_more;
    logic out_free;
  } status_t;

endpackage

### rtl/fcce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fcce_dp.sv
// Datapath of the cluster chain engine: link table, scan and walk registers, result register.
module fcce_dp import fcce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           sts_o,
  input  logic [1:0]        opcode_i,
  input  logic [IDX_W-1:0]  cluster_index_i,
  input  logic [DATA_W-1:0] entry_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] result_value_o,
  output logic              status_o,
  output logic [CNT_W-1:0]  freed_count_o
);

  logic [ENTRIES-1:0] vld_q;
  logic               vld_rd_q;
  logic               byp_q;
  logic [DATA_W-1:0]  byp_data_q;
  logic [DATA_W-1:0]  ram_rdata;
  logic [DATA_W-1:0]  rdata;

  logic               re;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [DATA_W-1:0]  wdata;

  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   scan_q, scan_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   cnt_inc;
  logic [DATA_W-1:0]  res_q, res_d;
  logic               sts_q, sts_d;

  logic               out_valid_q;
  logic [DATA_W-1:0]  out_res_q;
  logic               out_sts_q;
  logic [CNT_W-1:0]   out_cnt_q;

  fcce_ram #(
    .WIDTH(DATA_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // Entries never written read as free; a write to the address being read wins.
  assign rdata = byp_q ? byp_data_q : (vld_rd_q ? ram_rdata : '0);

  assign cnt_inc = cnt_q + CNT_W'(1);

  assign sts_o.rd_zero   = (rdata == '0);
  assign sts_o.scan_last = (scan_q == IDX_W'(ENTRIES - 1));
  assign sts_o.walk_more = (rdata >= DATA_W'(FIRST_USABLE)) && (rdata < DATA_W'(ENTRIES)) &&
                           (cnt_inc < CNT_W'(ENTRIES));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    re     = 1'b0;
    raddr  = cluster_index_i;
    we     = 1'b0;
    waddr  = cluster_index_i;
    wdata  = entry_value_i;
    idx_d  = idx_q;
    scan_d = scan_q;
    cur_d  = cur_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    sts_d  = sts_q;
    unique case (cmd_i.op)
      DP_ACCEPT: begin
        idx_d = cluster_index_i;
        cur_d = cluster_index_i;
        cnt_d = '0;
        res_d = '0;
        sts_d = 1'b0;
        unique case (opcode_e'(opcode_i))
          OP_READ:  re = 1'b1;
          OP_WRITE: we = 1'b1;
          OP_ALLOC: begin
            re     = 1'b1;
            raddr  = IDX_W'(FIRST_USABLE);
            scan_d = IDX_W'(FIRST_USABLE);
          end
          OP_FREE:  re = 1'b1;
        endcase
      end
      DP_RD_DONE: begin
        res_d = rdata;
      end
      DP_SCAN_STEP: begin
        re     = 1'b1;
        raddr  = scan_q + IDX_W'(1);
        scan_d = scan_q + IDX_W'(1);
      end
      DP_SCAN_HIT: begin
        res_d = DATA_W'(scan_q);
      end
      DP_SCAN_FULL: begin
        res_d = END_MARK;
        sts_d = 1'b1;
      end
      DP_LINK: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = res_q;
      end
      DP_MARK: begin
        we    = 1'b1;
        waddr = res_q[IDX_W-1:0];
        wdata = END_MARK;
      end
      DP_WALK: begin
        we    = 1'b1;
        waddr = cur_q;
        wdata = '0;
        cnt_d = cnt_inc;
        if (sts_o.walk_more) begin
          re    = 1'b1;
          raddr = rdata[IDX_W-1:0];
          cur_d = rdata[IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (re) begin
        vld_rd_q <= vld_q[raddr];
        byp_q    <= we && (waddr == raddr);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    scan_q <= scan_d;
    cur_q  <= cur_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
    sts_q  <= sts_d;
    if (re) begin
      byp_data_q <= wdata;
    end
    if (cmd_i.out_load) begin
      out_res_q <= res_q;
      out_sts_q <= sts_q;
      out_cnt_q <= cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign status_o       = out_sts_q;
  assign freed_count_o  = out_cnt_q;

endmodule

### rtl/fcce_ctrl.sv
// Controller state machine of the cluster chain engine.
module fcce_ctrl import fcce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  status_t    sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SCAN,
    S_LINK,
    S_MARK,
    S_WALK,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.op       = DP_NOP;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_ACCEPT;
          unique case (opcode_e'(opcode_i))
            OP_READ:  state_d = S_RD;
            OP_WRITE: state_d = S_RESP;
            OP_ALLOC: state_d = S_SCAN;
            OP_FREE:  state_d = S_WALK;
          endcase
        end
      end
      S_RD: begin
        cmd_o.op = DP_RD_DONE;
        state_d  = S_RESP;
      end
      S_SCAN: begin
        priority if (sts_i.rd_zero) begin
          cmd_o.op = DP_SCAN_HIT;
          state_d  = S_LINK;
        end else if (sts_i.scan_last) begin
          cmd_o.op = DP_SCAN_FULL;
          state_d  = S_RESP;
        end else begin
          cmd_o.op = DP_SCAN_STEP;
        end
      end
      S_LINK: begin
        cmd_o.op = DP_LINK;
        state_d  = S_MARK;
      end
      S_MARK: begin
        cmd_o.op = DP_MARK;
        state_d  = S_RESP;
      end
      S_WALK: begin
        cmd_o.op = DP_WALK;
        if (!sts_i.walk_more) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/fat_cluster_chain_engine_unit.sv
// Top level of the cluster chain engine: controller and datapath.
//
//   Channel | Handshake               | Payload
//   in      | in_valid_i / in_ready_o | opcode_i, cluster_index_i, entry_value_i
//   out     | out_valid_o/out_ready_i | result_value_o, status_o, freed_count_o
//
// A read goes through S_RD to S_RESP; a write goes from acceptance straight to S_RESP.
// An allocation scans from entry FIRST_USABLE up to entry ENTRIES - 1, then links and marks.
// A chain free walks the chain and clears each entry, for at most ENTRIES entries.
// The scan and the walk read the link table one entry at a time over its single read port.
// After reset every entry reads as free through per-entry valid bits; no clearing pass.
// A finished result waits in the output register while the next transaction is accepted.
module fat_cluster_chain_engine_unit import fcce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [IDX_W-1:0]  cluster_index_i,
  input  logic [DATA_W-1:0] entry_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] result_value_o,
  output logic              status_o,
  output logic [CNT_W-1:0]  freed_count_o
);

  cmd_t    cmd;
  status_t sts;

  fcce_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .opcode_i  (opcode_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fcce_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (opcode_i),
    .cluster_index_i(cluster_index_i),
    .entry_value_i  (entry_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .freed_count_o  (freed_count_o)
  );

endmodule

### rtl/fcce_chk.sv
// Port-level checker for the cluster chain engine and its bind statement.
`include "fat_cluster_chain_engine_unit_assert.svh"

module fcce_chk import fcce_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DATA_W-1:0] result_value_o,
  input logic              status_o,
  input logic [CNT_W-1:0]  freed_count_o
);

  `FCCE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_value_o) && $stable(status_o) && $stable(freed_count_o), "Stalled result transaction changed.")
  `FCCE_ASSERT_NOW(a_full_result, out_valid_o && status_o, result_value_o == END_MARK && freed_count_o == '0, "Full status with wrong result fields.")
  `FCCE_ASSERT_NOW(a_freed_bound, out_valid_o, freed_count_o <= CNT_W'(ENTRIES), "Freed count exceeds table size.")
  `FCCE_ASSERT_NOW(a_freed_only, out_valid_o && freed_count_o != '0, result_value_o == '0 && !status_o, "Free result carries other fields.")
  `FCCE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "Ready stayed high after an accepted transaction.")

endmodule

bind fat_cluster_chain_engine_unit fcce_chk u_chk (.*);

### dv/testbench.sv
// Testbench for the cluster chain engine: directed and random request streams checked against a shadow link table.
`timescale 1ns / 100ps

module testbench;
  import fcce_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int REPORT_MAX  = 10;
  localparam int FREED_MAX   = 511;
  localparam int STIM_TARGET = 560;
  localparam int HOLD_AFTER  = 40;
  localparam int HOLD_CYCLES = 900;

  typedef struct packed {
    opcode_e           op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
  } fat_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              full;
    logic [CNT_W-1:0]  freed;
  } fat_resp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        opcode = OP_READ;
  logic [IDX_W-1:0]  cluster_index = '0;
  logic [DATA_W-1:0] entry_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] result_value;
  logic              status;
  logic [CNT_W-1:0]  freed_count;

  logic [DATA_W-1:0] link_shadow [0:ENTRIES-1];
  fat_req_t          req_q [$];
  fat_resp_t         expect_q [$];
  fat_req_t          cur_req;
  fat_resp_t         got_resp;
  fat_resp_t         want_resp;

  logic send_took = 1'b0;
  logic recv_took = 1'b0;
  logic hold_done = 1'b0;
  int   send_gap = 0;
  int   send_calm = 0;
  int   recv_gap = 0;
  int   recv_calm = 0;
  int   hold_left = 0;
  int   accepted_n = 0;
  int   results_n = 0;
  int   mismatch_n = 0;
  int   total_n = 0;
  int   cycle_n = 0;

  fat_cluster_chain_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .cluster_index_i (cluster_index),
    .entry_value_i   (entry_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .result_value_o  (result_value),
    .status_o        (status),
    .freed_count_o   (freed_count)
  );

  always #2 clk_i = ~clk_i;

  function automatic fat_resp_t fat_apply(fat_req_t r);
    fat_resp_t o;
    int        slot;
    int        cur;
    int        nxt;
    int        steps;
    int        i;
    bit        in_range;
    o = '0;
    in_range = r.idx < ENTRIES;
    case (r.op)
      OP_READ: begin
        if (in_range) o.value = link_shadow[r.idx];
      end
      OP_WRITE: begin
        if (in_range) link_shadow[r.idx] = r.val;
      end
      OP_ALLOC: begin
        slot = -1;
        for (i = FIRST_USABLE; i < ENTRIES && slot < 0; i++) begin
          if (link_shadow[i] == '0) slot = i;
        end
        if (slot < 0) begin
          o.value = END_MARK;
          o.full = 1'b1;
        end else begin
          // The link goes in first, so extending the slot itself leaves the end mark.
          if (in_range) link_shadow[r.idx] = slot[DATA_W-1:0];
          link_shadow[slot] = END_MARK;
          o.value = slot[DATA_W-1:0];
        end
      end
      default: begin
        if (in_range) begin
          cur = r.idx;
          for (steps = 0; steps < ENTRIES; steps++) begin
            nxt = link_shadow[cur];
            link_shadow[cur] = '0;
            if (o.freed < FREED_MAX) o.freed = o.freed + 1'b1;
            if (nxt >= FIRST_USABLE && nxt < ENTRIES) cur = nxt;
            else break;
          end
        end
      end
    endcase
    return o;
  endfunction

  function automatic void queue_req(opcode_e op, int idx, int val);
    fat_req_t r;
    r.op = op;
    r.idx = idx[IDX_W-1:0];
    r.val = val[DATA_W-1:0];
    req_q.push_back(r);
  endfunction

  function automatic void report_mismatch(string what, fat_resp_t want, fat_resp_t got);
    mismatch_n++;
    if (mismatch_n <= REPORT_MAX) begin
      $display("%0t: %s: expected value %h status %0d freed %0d, got value %h status %0d freed %0d",
               $time, what, want.value, want.full, want.freed, got.value, got.full, got.freed);
    end
  endfunction

  task automatic draw_gap(inout int calm_left, output int gap);
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(8, 30);
      gap = $urandom_range(0, 11);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || send_took)) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        cur_req = req_q.pop_front();
        opcode <= cur_req.op;
        cluster_index <= cur_req.idx;
        entry_value <= cur_req.val;
        in_valid <= 1'b1;
        draw_gap(send_calm, send_gap);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    send_took <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      expect_q.push_back(fat_apply(cur_req));
      accepted_n <= accepted_n + 1;
    end
  end

  // One long receiver hold-off lets the engine back up into its input channel.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_n >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (recv_took) draw_gap(recv_calm, recv_gap);
    if (recv_gap > 0) begin
      recv_gap = recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni && hold_left == 0;
    end
  end

  always @(posedge clk_i) begin
    recv_took <= out_valid && out_ready;
    if (out_valid && out_ready) begin
      got_resp.value = result_value;
      got_resp.full = status;
      got_resp.freed = freed_count;
      results_n <= results_n + 1;
      if (expect_q.size() == 0) begin
        report_mismatch("transaction with nothing pending", '0, got_resp);
      end else begin
        want_resp = expect_q.pop_front();
        if (got_resp.value !== want_resp.value || got_resp.full !== want_resp.full ||
            got_resp.freed !== want_resp.freed) begin
          report_mismatch("field mismatch", want_resp, got_resp);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int k;
    int j;
    int t;
    int pick;
    int perm [0:253];
    int hops [0:7];
    bit filled;
    filled = 1'b0;
    foreach (link_shadow[i]) link_shadow[i] = '0;

    queue_req(OP_READ, 0, 0);
    queue_req(OP_READ, 255, 0);
    queue_req(OP_WRITE, 255, 16'hFFFF);
    queue_req(OP_READ, 255, 16'hFFFF);
    queue_req(OP_WRITE, 0, 16'hA5A5);
    queue_req(OP_READ, 0, 0);
    queue_req(OP_ALLOC, 0, 0);
    queue_req(OP_ALLOC, 2, 0);
    queue_req(OP_ALLOC, 3, 16'hFFFF);
    queue_req(OP_READ, 2, 0);
    queue_req(OP_ALLOC, 5, 0);
    queue_req(OP_READ, 5, 0);
    queue_req(OP_FREE, 2, 0);
    queue_req(OP_WRITE, 20, 21);
    queue_req(OP_WRITE, 21, 20);
    queue_req(OP_FREE, 20, 0);
    queue_req(OP_WRITE, 30, 1);
    queue_req(OP_FREE, 30, 0);
    queue_req(OP_FREE, 31, 0);
    queue_req(OP_WRITE, 40, 16'h0100);
    queue_req(OP_FREE, 40, 0);
    queue_req(OP_WRITE, 254, 255);
    queue_req(OP_FREE, 254, 0);
    queue_req(OP_WRITE, 100, 16'h8000);
    queue_req(OP_READ, 100, 0);

    while (req_q.size() < STIM_TARGET) begin
      if (!filled && req_q.size() > 200) begin
        // A shuffled chain through every usable entry fills the table before it is freed.
        filled = 1'b1;
        for (k = 0; k < 254; k++) perm[k] = k + FIRST_USABLE;
        for (k = 253; k > 0; k--) begin
          j = $urandom_range(0, k);
          t = perm[k];
          perm[k] = perm[j];
          perm[j] = t;
        end
        queue_req(OP_WRITE, 1, perm[0]);
        for (k = 0; k < 253; k++) queue_req(OP_WRITE, perm[k], perm[k + 1]);
        queue_req(OP_WRITE, perm[253], END_MARK);
        for (k = 0; k < 3; k++) queue_req(OP_ALLOC, $urandom_range(0, 255), $urandom);
        queue_req(OP_FREE, 1, $urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        k = $urandom_range(1, 8);
        for (j = 0; j < k; j++) hops[j] = $urandom_range(FIRST_USABLE, ENTRIES - 1);
        for (j = 0; j + 1 < k; j++) queue_req(OP_WRITE, hops[j], hops[j + 1]);
        case ($urandom_range(0, 4))
          0: t = END_MARK;
          1: t = $urandom_range(0, 1);
          2: t = $urandom_range(ENTRIES, 16'hFFFE);
          3: t = hops[0];
          default: t = $urandom_range(0, 16'hFFFF);
        endcase
        queue_req(OP_WRITE, hops[k - 1], t);
        if ($urandom_range(0, 2) == 0) queue_req(OP_READ, hops[$urandom_range(0, k - 1)], $urandom);
        queue_req(OP_FREE, ($urandom_range(0, 3) == 0) ? hops[k / 2] : hops[0], $urandom);
      end else if (pick < 8) begin
        k = $urandom_range(1, 4);
        for (j = 0; j < k; j++) begin
          t = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
          queue_req(OP_ALLOC, t, $urandom);
        end
      end else begin
        queue_req(opcode_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                  $urandom_range(0, 16'hFFFF));
      end
    end
    total_n = req_q.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (accepted_n != total_n || expect_q.size() != 0);
    repeat (ENTRIES + 16) @(posedge clk_i);
    if (mismatch_n == 0 && expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
